@@ src/spm_pkg.sv @@
package spm_pkg;

    localparam int VALUE_W            = 32;
    localparam int SUM_W              = 42;
    localparam int CFG_W              = 10;
    localparam int NQ_W               = 4;
    localparam int IN_ADDR_W          = 10;
    localparam int EFF_W              = 10;
    localparam int REG_IDX_W          = 2;
    localparam int DEFAULT_MAX_QUBITS = 10;

    // register indexes on the config port
    localparam logic [REG_IDX_W-1:0] REG_NUM_QUBITS = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_COMP_MASK  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SIGN_MASK  = 2'd2;

    localparam logic [NQ_W-1:0]  NUM_QUBITS_RST = 4'd10;
    localparam logic [CFG_W-1:0] MASK_RST       = '0;

    // op codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // 10.0 in Q17.24
    localparam logic signed [SUM_W-1:0] LIMIT_Q24 = 42'sd167772160;

endpackage

@@ src/spm_store.sv @@
module spm_store #(
    parameter int ADDR_W = spm_pkg::DEFAULT_MAX_QUBITS
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [ADDR_W-1:0]          waddr,
    input  logic [spm_pkg::VALUE_W-1:0] wdata,
    input  logic [ADDR_W-1:0]          raddr,
    output logic [spm_pkg::VALUE_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [spm_pkg::VALUE_W-1:0] mem [DEPTH];
    logic [spm_pkg::VALUE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/signed_parity_marginalizer.sv @@
// Load beat: written to the store at the accepting edge; in_ready stays high, one load per cycle.
// Query beat: in_ready drops until the result is registered; m = non-computational qubits in use.
// ST_DEPOSIT places the effective bits, ST_WALK makes 2^m reads of the store, then ST_DRAIN
// and ST_FINISH. No new beat is taken until the query is done; ST_FINISH also waits while the output
// register still holds an untaken result.
// Reset (rst_n, async, low) sets num_qubits to 10, masks to 0; store contents undefined.
module signed_parity_marginalizer #(
    parameter int MAX_QUBITS = spm_pkg::DEFAULT_MAX_QUBITS
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_write,
    input  logic [spm_pkg::REG_IDX_W-1:0]     cfg_addr,
    input  logic [spm_pkg::CFG_W-1:0]         cfg_wdata,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              op,
    input  logic [spm_pkg::IN_ADDR_W-1:0]     load_addr,
    input  logic signed [spm_pkg::VALUE_W-1:0] load_value,
    input  logic [spm_pkg::EFF_W-1:0]         eff_state,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [spm_pkg::SUM_W-1:0]  sum,
    output logic                              over_limit
);

    localparam int AW = MAX_QUBITS;
    localparam int IW = (AW > 1) ? $clog2(AW) : 1;
    localparam int NW = $clog2(AW + 1);
    localparam int SW = spm_pkg::SUM_W;
    localparam int VW = spm_pkg::VALUE_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEPOSIT,
        ST_WALK,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t                   state_reg, state_next;
    logic [spm_pkg::NQ_W-1:0] num_qubits_reg;
    logic [spm_pkg::CFG_W-1:0] comp_mask_reg, sign_mask_reg;

    logic [AW-1:0]            eff_reg, eff_next;
    logic [AW-1:0]            base_reg, base_next;
    logic [AW-1:0]            sub_reg, sub_next;
    logic [IW-1:0]            pos_reg, pos_next;
    logic [IW-1:0]            k_reg, k_next;
    logic                     rd_valid_reg, rd_valid_next;
    logic                     rd_neg_reg, rd_neg_next;
    logic signed [SW-1:0]     acc_reg, acc_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [SW-1:0]     sum_reg, sum_next;
    logic                     over_reg, over_next;

    logic [NW-1:0]            nq_eff;
    logic [AW-1:0]            full_w, comp_w, other_w, signs_w;
    logic                     in_fire;
    logic                     mem_we;
    logic [AW-1:0]            raddr;
    logic [VW-1:0]            rdata;
    logic signed [SW-1:0]     term;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_qubits_reg <= spm_pkg::NUM_QUBITS_RST;
            comp_mask_reg  <= spm_pkg::MASK_RST;
            sign_mask_reg  <= spm_pkg::MASK_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_addr)
                spm_pkg::REG_NUM_QUBITS: num_qubits_reg <= cfg_wdata[spm_pkg::NQ_W-1:0];
                spm_pkg::REG_COMP_MASK:  comp_mask_reg  <= cfg_wdata;
                spm_pkg::REG_SIGN_MASK:  sign_mask_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // effective qubit count and derived masks
    always_comb
    begin
        priority if (num_qubits_reg == '0)
            nq_eff = NW'(1);
        else if (32'(num_qubits_reg) > AW)
            nq_eff = NW'(AW);
        else
            nq_eff = NW'(num_qubits_reg);
        for (int i = 0; i < AW; i++)
        begin
            full_w[i] = (i < 32'(nq_eff));
        end
        comp_w  = AW'(comp_mask_reg) & full_w;
        other_w = full_w & ~comp_w;
        signs_w = AW'(sign_mask_reg) & other_w;
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign raddr    = base_reg | sub_reg;
    assign term     = {{(SW-VW){rdata[VW-1]}}, rdata};

    spm_store #(
        .ADDR_W (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (AW'(load_addr)),
        .wdata (load_value),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        eff_next       = eff_reg;
        base_next      = base_reg;
        sub_next       = sub_reg;
        pos_next       = pos_reg;
        k_next         = k_reg;
        rd_valid_next  = 1'b0;
        rd_neg_next    = rd_neg_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !out_ready;
        sum_next       = sum_reg;
        over_next      = over_reg;
        mem_we         = 1'b0;

        // previous read beat lands in the accumulator
        if (rd_valid_reg)
        begin
            acc_next = rd_neg_reg ? (acc_reg - term) : (acc_reg + term);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (op == spm_pkg::OP_LOAD)
                    begin
                        mem_we = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_DEPOSIT;
                        eff_next   = AW'(eff_state);
                        base_next  = '0;
                        sub_next   = '0;
                        pos_next   = '0;
                        k_next     = '0;
                        acc_next   = '0;
                    end
                end
            end
            ST_DEPOSIT:
            begin
                // one qubit position per cycle
                if (comp_w[pos_reg])
                begin
                    base_next[pos_reg] = eff_reg[k_reg];
                    k_next             = k_reg + 1'b1;
                end
                if (pos_reg == IW'(AW - 1))
                    state_next = ST_WALK;
                else
                    pos_next = pos_reg + 1'b1;
            end
            ST_WALK:
            begin
                rd_valid_next = 1'b1;
                rd_neg_next   = ^(sub_reg & signs_w);
                if (sub_reg == other_w)
                    state_next = ST_DRAIN;
                else
                    sub_next = (sub_reg - other_w) & other_w;
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    sum_next       = acc_reg;
                    over_next      = (other_w != '0) && (acc_reg > spm_pkg::LIMIT_Q24);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        eff_reg    <= eff_next;
        base_reg   <= base_next;
        sub_reg    <= sub_next;
        pos_reg    <= pos_next;
        k_reg      <= k_next;
        rd_neg_reg <= rd_neg_next;
        acc_reg    <= acc_next;
        sum_reg    <= sum_next;
        over_reg   <= over_next;
    end

    assign out_valid  = out_valid_reg;
    assign sum        = sum_reg;
    assign over_limit = over_reg;

`ifndef SYNTHESIS
    a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && op == spm_pkg::OP_QUERY |=> state_reg == ST_DEPOSIT && acc_reg == '0)
        else $error("query did not start a clean deposit");

    a_base_in_comp: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> (base_reg & ~comp_w) == '0)
        else $error("base index has bits outside computational qubits");

    a_sub_in_other: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> (sub_reg & ~other_w) == '0)
        else $error("walk index left the non-computational qubits");

    a_read_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> $past(state_reg == ST_WALK))
        else $error("read beat without a walk cycle");

    a_over_means_large: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && over_reg |-> sum_reg > spm_pkg::LIMIT_Q24)
        else $error("over_limit set on a small sum");
`endif

endmodule

@@ dv/spm_checker.sv @@
module spm_checker (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_write,
    input  logic [spm_pkg::REG_IDX_W-1:0]       cfg_addr,
    input  logic [spm_pkg::CFG_W-1:0]           cfg_wdata,

    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                op,
    input  logic [spm_pkg::IN_ADDR_W-1:0]       load_addr,
    input  logic signed [spm_pkg::VALUE_W-1:0]  load_value,
    input  logic [spm_pkg::EFF_W-1:0]           eff_state,

    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic signed [spm_pkg::SUM_W-1:0]    sum,
    input  logic                                over_limit,

    output int                                  mismatches,
    output int                                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUBITS_MAX  = spm_pkg::DEFAULT_MAX_QUBITS;
    localparam int STORE_DEPTH = 1 << spm_pkg::DEFAULT_MAX_QUBITS;

    typedef struct packed {
        logic signed [spm_pkg::SUM_W-1:0] total;
        logic                             over;
    } marginal_t;

    logic signed [spm_pkg::VALUE_W-1:0] prob_mem [0:STORE_DEPTH-1];
    logic [spm_pkg::NQ_W-1:0]           qubits_q;
    logic [spm_pkg::CFG_W-1:0]          comp_q;
    logic [spm_pkg::CFG_W-1:0]          sign_q;
    marginal_t                          marginals_due [$];

    function automatic marginal_t marginal_of(input logic [spm_pkg::EFF_W-1:0] eff);
        int                               width;
        int                               k;
        logic [spm_pkg::CFG_W-1:0]        span;
        logic [spm_pkg::CFG_W-1:0]        comp;
        logic [spm_pkg::CFG_W-1:0]        signs;
        logic [spm_pkg::CFG_W-1:0]        base;
        logic [spm_pkg::IN_ADDR_W-1:0]    idx;
        logic signed [spm_pkg::SUM_W-1:0] term;
        logic signed [spm_pkg::SUM_W-1:0] acc;
        marginal_t                        r;

        width = (qubits_q == '0) ? 1 : ((int'(qubits_q) > QUBITS_MAX) ? QUBITS_MAX
                                                                       : int'(qubits_q));
        span  = {spm_pkg::CFG_W{1'b1}} >> (spm_pkg::CFG_W - width);
        comp  = comp_q & span;
        signs = sign_q & span & ~comp;

        // effective bits go into the computational positions, low bit first
        base = '0;
        k    = 0;
        for (int p = 0; p < spm_pkg::CFG_W; p++) begin
            if (comp[p]) begin
                base[p] = eff[k];
                k++;
            end
        end

        acc = '0;
        for (int s = 0; s < STORE_DEPTH; s++) begin
            idx = spm_pkg::IN_ADDR_W'(s);
            if ((idx & ~span) == '0 && (idx & comp) == base) begin
                term = prob_mem[idx];
                if (^(idx & signs))
                    acc = acc - term;
                else
                    acc = acc + term;
            end
        end

        r.total = acc;
        // no limit check when every qubit is computational
        r.over  = (comp != span) && (acc > spm_pkg::LIMIT_Q24);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        marginal_t head;

        if (!rst_n) begin
            qubits_q   = spm_pkg::NUM_QUBITS_RST;
            comp_q     = spm_pkg::MASK_RST;
            sign_q     = spm_pkg::MASK_RST;
            marginals_due.delete();
            pending    = 0;
            mismatches = 0;
        end else begin
            if (cfg_write) begin
                case (cfg_addr)
                    spm_pkg::REG_NUM_QUBITS: qubits_q = cfg_wdata[spm_pkg::NQ_W-1:0];
                    spm_pkg::REG_COMP_MASK:  comp_q   = cfg_wdata;
                    spm_pkg::REG_SIGN_MASK:  sign_q   = cfg_wdata;
                    default: ;
                endcase
            end

            if (out_valid && out_ready) begin
                if (marginals_due.size() == 0) begin
                    $error("result beat with no query outstanding: sum %0d", sum);
                    mismatches++;
                end else begin
                    head = marginals_due.pop_front();
                    if (sum !== head.total) begin
                        $error("sum: expected %0d, actual %0d", head.total, sum);
                        mismatches++;
                    end
                    if (over_limit !== head.over) begin
                        $error("over_limit: expected %0b, actual %0b", head.over, over_limit);
                        mismatches++;
                    end
                end
            end

            if (in_valid && in_ready) begin
                if (op == spm_pkg::OP_LOAD)
                    prob_mem[load_addr] = load_value;
                else
                    marginals_due.push_back(marginal_of(eff_state));
            end

            pending = marginals_due.size();
        end
    end

endmodule

@@ dv/signed_parity_marginalizer_tb.sv @@
module signed_parity_marginalizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD      = 10;
    localparam int STORE_DEPTH     = 1 << spm_pkg::DEFAULT_MAX_QUBITS;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 62;
    localparam int SETTLE_CYCLES   = 16;
    localparam int TAIL_CYCLES     = 1100;
    localparam int LIMIT_CYCLES    = 4000000;
    localparam int VW              = spm_pkg::VALUE_W;
    localparam int CW              = spm_pkg::CFG_W;
    localparam int AW              = spm_pkg::IN_ADDR_W;
    localparam int EW              = spm_pkg::EFF_W;

    // index 3 has no register behind it; writes there are dropped
    localparam logic [spm_pkg::REG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam logic signed [VW-1:0] VALUE_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [VW-1:0] VALUE_MIN   = 32'sh8000_0000;
    localparam logic signed [VW-1:0] LIMIT_VALUE = VW'(spm_pkg::LIMIT_Q24);

    typedef enum logic [1:0] {
        PACE_STEADY,
        PACE_SENDER_IDLE,
        PACE_RECEIVER_STALL,
        PACE_BOTH
    } pace_t;

    logic                               clk        = 1'b0;
    logic                               rst_n      = 1'b0;
    logic                               cfg_write  = 1'b0;
    logic [spm_pkg::REG_IDX_W-1:0]      cfg_addr   = '0;
    logic [CW-1:0]                      cfg_wdata  = '0;
    logic                               in_valid   = 1'b0;
    logic                               in_ready;
    logic                               op         = spm_pkg::OP_LOAD;
    logic [AW-1:0]                      load_addr  = '0;
    logic signed [VW-1:0]               load_value = '0;
    logic [EW-1:0]                      eff_state  = '0;
    logic                               out_valid;
    logic                               out_ready  = 1'b0;
    logic signed [spm_pkg::SUM_W-1:0]   sum;
    logic                               over_limit;

    int          mismatches;
    int          pending;
    int          cycle_count     = 0;
    int unsigned sender_idle_pct = 0;
    int unsigned stall_pct       = 0;

    signed_parity_marginalizer u_dut (.*);

    spm_checker u_checker (.*);

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= stall_pct);

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("signed_parity_marginalizer_tb: FAIL");
            $finish;
        end
    end

    task automatic set_pace(input pace_t pace);
        case (pace)
            PACE_STEADY:         begin sender_idle_pct = 0;  stall_pct = 0;  end
            PACE_SENDER_IDLE:    begin sender_idle_pct = 66; stall_pct = 0;  end
            PACE_RECEIVER_STALL: begin sender_idle_pct = 0;  stall_pct = 66; end
            default:             begin sender_idle_pct = 25; stall_pct = 25; end
        endcase
    endtask

    // hold off the input until every query has returned its result
    task automatic drain(input int settle);
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (settle) @(negedge clk);
    endtask

    task automatic set_config(input logic [CW-1:0] nq_word,
                              input logic [CW-1:0] comp_word,
                              input logic [CW-1:0] sign_word);
        drain(SETTLE_CYCLES);
        cfg_write <= 1'b1;
        cfg_addr  <= REG_SPARE;
        cfg_wdata <= CW'($urandom);
        @(negedge clk);
        cfg_addr  <= spm_pkg::REG_NUM_QUBITS;
        cfg_wdata <= nq_word;
        @(negedge clk);
        cfg_addr  <= spm_pkg::REG_COMP_MASK;
        cfg_wdata <= comp_word;
        @(negedge clk);
        cfg_addr  <= spm_pkg::REG_SIGN_MASK;
        cfg_wdata <= sign_word;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_beat(input logic                 kind,
                             input logic [AW-1:0]        addr,
                             input logic signed [VW-1:0] value,
                             input logic [EW-1:0]        eff);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        op         <= kind;
        load_addr  <= addr;
        load_value <= value;
        eff_state  <= eff;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic load(input logic [AW-1:0] addr, input logic signed [VW-1:0] value);
        send_beat(spm_pkg::OP_LOAD, addr, value, EW'($urandom));
    endtask

    task automatic query(input logic [EW-1:0] eff);
        send_beat(spm_pkg::OP_QUERY, AW'($urandom), VW'($urandom), eff);
    endtask

    function automatic logic signed [VW-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return VALUE_MAX;
            1:       return VALUE_MIN;
            2:       return LIMIT_VALUE - VW'(2) + VW'($urandom_range(0, 4));
            3:       return VW'($urandom_range(0, 32'h0200_0000)) - VW'(32'h0100_0000);
            default: return VW'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        int unsigned   nq_raw;
        int unsigned   eff_nq;
        logic [CW-1:0] comp_word;
        logic [CW-1:0] sign_word;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // fill the whole store: even parity at full scale, odd parity at negative full scale
        set_pace(PACE_STEADY);
        for (int a = 0; a < STORE_DEPTH; a++)
            load(AW'(a), (^(AW'(a))) ? VALUE_MIN : VALUE_MAX);

        // reset settings: ten qubits, all summed without sign
        query('0);
        // every qubit signed: sum reaches near the top of the 42-bit range
        set_config(10'd10, 10'h000, 10'h3FF);
        query('1);
        // all qubits computational: single value, no limit flag
        set_config(10'd10, 10'h3FF, 10'h000);
        query('1);
        query(10'd1);
        // limit boundary at exactly 10.0 and one lsb above
        set_config(10'd1, 10'h000, 10'h000);
        load(10'd0, LIMIT_VALUE);
        load(10'd1, '0);
        query('0);
        load(10'd0, LIMIT_VALUE + VW'(1));
        query('0);
        // zero qubits acts as one; surplus effective bits dropped
        set_config(10'd0, 10'h001, 10'h000);
        query(10'd1);
        query(10'h3FE);
        // count above max with junk in the upper write bits acts as max
        set_config(10'h3FF, 10'h3FE, 10'h001);
        query('0);
        query(10'h1FF);
        // mask bits above the qubit count ignored
        set_config(10'd3, 10'h3FA, 10'h3FF);
        query('1);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0:       begin nq_raw = 10; comp_word = '1; sign_word = '1; end
                1:       begin nq_raw = 0;  comp_word = '0; sign_word = '1; end
                2:       begin nq_raw = 15; comp_word = CW'($urandom); sign_word = '0; end
                default: begin
                    nq_raw    = $urandom_range(0, 15);
                    comp_word = CW'($urandom);
                    sign_word = CW'($urandom);
                end
            endcase
            eff_nq = (nq_raw == 0) ? 1
                   : ((nq_raw > spm_pkg::DEFAULT_MAX_QUBITS) ? spm_pkg::DEFAULT_MAX_QUBITS
                                                              : nq_raw);
            // keep wide configs cheap: at most six summed qubits
            if (eff_nq > 6)
                comp_word = comp_word | 10'h3C0;

            set_config((CW'($urandom_range(0, 63)) << spm_pkg::NQ_W) | CW'(nq_raw),
                       comp_word, sign_word);
            set_pace(pace_t'(ph % 4));

            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if ($urandom_range(0, 39) == 0)
                    drain(0);
                if ($urandom_range(0, 99) < 35)
                    load(AW'($urandom), pick_value());
                else
                    query(EW'($urandom));
            end
        end

        drain(SETTLE_CYCLES);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (mismatches == 0 && pending == 0)
            $display("signed_parity_marginalizer_tb: PASS");
        else
            $display("signed_parity_marginalizer_tb: FAIL");
        $finish;
    end

endmodule
